// ===== sv/sbd_pkg.sv =====
// Package for the six-bit block deframer: codes, constants and the structs
// passed between its stages. No dependencies.
`default_nettype none

package sbd_pkg;

    localparam logic [7:0]  MARK_BYTE = 8'h1F;
    localparam logic [7:0]  OPEN_BYTE = 8'h3C;
    localparam logic [7:0]  DATA_MIN  = 8'h40;
    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_MARK = 3'd1,
        PH_HDR0 = 3'd2,
        PH_HDR1 = 3'd3,
        PH_HDR2 = 3'd4,
        PH_DATA = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    // Byte held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_slot;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  bank;
        logic [15:0] load_address;
        logic [7:0]  data_byte;
        logic [23:0] byte_count;
    } t_result;

    // Load request from the decoder into the result register.
    typedef struct packed {
        logic    load;
        t_result res;
    } t_result_req;

endpackage

`default_nettype wire

// ===== sv/sbd_byte_if.sv =====
// Byte input channel of the six-bit block deframer: valid, ready, raw byte.
// No dependencies.
`default_nettype none

interface sbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/sbd_result_if.sv =====
// Result channel of the six-bit block deframer: valid, ready, result fields.
// No dependencies.
`default_nettype none

interface sbd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  bank;
    logic [15:0] load_address;
    logic [7:0]  data_byte;
    logic [23:0] byte_count;

    modport source (output valid, output kind, output bank, output load_address,
                    output data_byte, output byte_count, input ready);
    modport sink   (input valid, input kind, input bank, input load_address,
                    input data_byte, input byte_count, output ready);
endinterface

`default_nettype wire

// ===== sv/sbd_in_reg.sv =====
// Input register of the six-bit block deframer.
// Depends on sbd_pkg and sbd_byte_if.
`default_nettype none

module sbd_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sbd_byte_if.sink           i_in,
    input  wire logic          i_advance,
    output sbd_pkg::t_byte_slot o_slot
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data;
    logic       accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_data <= i_in.in_byte;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.data  = r_data;

endmodule

`default_nettype wire

// ===== sv/sbd_decode.sv =====
// Deframing state and per-byte decode of the six-bit block deframer.
// Depends on sbd_pkg.
`default_nettype none

module sbd_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sbd_pkg::t_byte_slot i_slot,
    input  wire logic           i_out_free,
    output logic                o_advance,
    output sbd_pkg::t_result_req o_req
);

    sbd_pkg::t_phase r_phase, n_phase;
    logic [11:0] r_header_bits, n_header_bits;
    logic [5:0]  r_pending_bits, n_pending_bits;
    logic [2:0]  r_pending_count, n_pending_count;
    logic [1:0]  r_block_bank, n_block_bank;
    logic [15:0] r_block_address, n_block_address;
    logic [23:0] r_decoded_count, n_decoded_count;

    logic [7:0]  b;
    logic [5:0]  six;
    logic        is_data;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [2:0]  sh;
    logic [5:0]  keep_mask;
    logic [17:0] hdr;
    logic        res_valid;
    sbd_pkg::t_result res;

    assign b       = i_slot.data;
    assign six     = b[5:0];
    assign is_data = (b >= sbd_pkg::DATA_MIN);
    assign acc     = {r_pending_bits, six};
    assign cnt     = {1'b0, r_pending_count} + 4'd6;
    assign sh      = 3'(cnt - 4'd8);
    assign keep_mask = 6'((7'd1 << sh) - 7'd1);
    assign hdr     = {r_header_bits, six};

    // Only a byte that yields a result needs the result register free.
    assign o_advance = i_slot.valid && (!res_valid || i_out_free);
    assign o_req.load = o_advance && res_valid;
    assign o_req.res  = res;

    // Next phase
    always_comb begin
        case (r_phase)
            sbd_pkg::PH_MARK: begin
                n_phase = (b == sbd_pkg::OPEN_BYTE) ? sbd_pkg::PH_HDR0 : sbd_pkg::PH_HUNT;
            end
            sbd_pkg::PH_HDR0: n_phase = sbd_pkg::PH_HDR1;
            sbd_pkg::PH_HDR1: n_phase = sbd_pkg::PH_HDR2;
            sbd_pkg::PH_HDR2: n_phase = sbd_pkg::PH_DATA;
            sbd_pkg::PH_DATA: begin
                n_phase = is_data ? sbd_pkg::PH_DATA : sbd_pkg::PH_HUNT;
            end
            default: begin
                n_phase = (b == sbd_pkg::MARK_BYTE) ? sbd_pkg::PH_MARK : sbd_pkg::PH_HUNT;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        n_header_bits   = r_header_bits;
        n_pending_bits  = r_pending_bits;
        n_pending_count = r_pending_count;
        n_block_bank    = r_block_bank;
        n_block_address = r_block_address;
        n_decoded_count = r_decoded_count;
        res_valid       = 1'b0;
        res.kind        = sbd_pkg::KIND_START;
        res.data_byte   = 8'd0;
        case (r_phase)
            sbd_pkg::PH_HDR0: n_header_bits = {6'd0, six};
            sbd_pkg::PH_HDR1: n_header_bits = {r_header_bits[5:0], six};
            sbd_pkg::PH_HDR2: begin
                n_block_bank    = hdr[17:16];
                n_block_address = hdr[15:0];
                n_pending_bits  = 6'd0;
                n_pending_count = 3'd0;
                n_decoded_count = 24'd0;
                res_valid       = 1'b1;
            end
            sbd_pkg::PH_DATA: begin
                if (is_data) begin
                    if (cnt >= 4'd8) begin
                        n_pending_bits  = acc[5:0] & keep_mask;
                        n_pending_count = sh;
                        if (r_decoded_count != sbd_pkg::COUNT_MAX) begin
                            n_decoded_count = r_decoded_count + 24'd1;
                        end
                        res_valid     = 1'b1;
                        res.kind      = sbd_pkg::KIND_DATA;
                        res.data_byte = 8'(acc >> sh);
                    end else begin
                        n_pending_bits  = six;
                        n_pending_count = cnt[2:0];
                    end
                end else begin
                    n_pending_bits  = 6'd0;
                    n_pending_count = 3'd0;
                    res_valid       = 1'b1;
                    res.kind        = sbd_pkg::KIND_END;
                    res.data_byte   = b;
                end
            end
            default: ;
        endcase
        res.bank          = n_block_bank;
        res.load_address  = n_block_address;
        res.byte_count    = n_decoded_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= sbd_pkg::PH_HUNT;
            r_header_bits   <= 12'd0;
            r_pending_bits  <= 6'd0;
            r_pending_count <= 3'd0;
            r_block_bank    <= 2'd0;
            r_block_address <= 16'd0;
            r_decoded_count <= 24'd0;
        end else if (o_advance) begin
            r_phase         <= n_phase;
            r_header_bits   <= n_header_bits;
            r_pending_bits  <= n_pending_bits;
            r_pending_count <= n_pending_count;
            r_block_bank    <= n_block_bank;
            r_block_address <= n_block_address;
            r_decoded_count <= n_decoded_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sbd_out_reg.sv =====
// Result register of the six-bit block deframer.
// Depends on sbd_pkg and sbd_result_if.
`default_nettype none

module sbd_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sbd_pkg::t_result_req i_req,
    output logic                 o_free,
    sbd_result_if.source         o_out
);

    logic             r_valid;
    logic             n_valid;
    sbd_pkg::t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        if (i_req.load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_req.load) begin
            r_res <= i_req.res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.kind          = r_res.kind;
    assign o_out.bank          = r_res.bank;
    assign o_out.load_address  = r_res.load_address;
    assign o_out.data_byte     = r_res.data_byte;
    assign o_out.byte_count    = r_res.byte_count;

endmodule

`default_nettype wire

// ===== sv/six_bit_block_deframer.sv =====
// Top level of the six-bit block deframer.
// Depends on sbd_pkg, sbd_byte_if, sbd_result_if, sbd_in_reg, sbd_decode, sbd_out_reg.
//
//  channel  direction  payload                                             notes
//  i_in     sink       in_byte[7:0]                                        raw stream
//  o_out    source     kind, bank, load_address, data_byte, byte_count     0 or 1 per byte
//
// One byte per cycle sustained while the output side takes results. A byte
// goes input register -> decode -> result register, and its result is
// registered in the result register once that register is free. Bytes that
// yield no result retire regardless of the output side; a byte that yields
// a result waits in the input register only while the result register is
// full and not being taken. Synchronous active-low reset returns to marker
// hunting with both registers empty.
`default_nettype none

module six_bit_block_deframer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sbd_byte_if.sink     i_in,
    sbd_result_if.source o_out
);

    sbd_pkg::t_byte_slot  in_slot;
    sbd_pkg::t_result_req out_req;
    logic                 advance;
    logic                 out_free;

    // Input register: takes a new byte whenever it is empty or the held one moves on.
    sbd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_slot    (in_slot)
    );

    // Marker hunt, header assembly and 6-to-8 bit repacking.
    sbd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slot     (in_slot),
        .i_out_free (out_free),
        .o_advance  (advance),
        .o_req      (out_req)
    );

    // Result register: parts the output handshake from the decoder.
    sbd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (out_req),
        .o_free  (out_free),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // A held byte that cannot retire must block the next transaction.
    a_in_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_slot.valid && !advance) |-> !i_in.ready)
        else $error("input taken while held byte is stuck");

    // Never overwrite a result that is still waiting.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !out_req.load)
        else $error("pending result overwritten");

    // A data result always counts at least itself.
    a_data_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == sbd_pkg::KIND_DATA) |-> (o_out.byte_count != 24'd0))
        else $error("data result with zero count");

    // A header result carries an empty count and data byte.
    a_start_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == sbd_pkg::KIND_START)
            |-> (o_out.byte_count == 24'd0 && o_out.data_byte == 8'd0))
        else $error("header result with non-zero count or data");
`endif

endmodule

`default_nettype wire
